/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* rtl/tss_pkg.sv */
// ----------------------------------------------------------------------------
// tss_pkg
// Types, constants and helpers shared by the tetrahedron strain scale block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tss_pkg;

    // Field widths
    localparam int DATA_W      = 32;
    localparam int COORD_WIDTH = 32;   // differences clip to COORD_WIDTH+1 signed bits
    localparam int DIFF_W      = DATA_W + 1;
    localparam int NUM_NB      = 3;    // stored neighbors
    localparam int NUM_AXES    = 3;
    localparam int FRAC_W      = 28;

    // Stream widths
    localparam int S_TDATA_W = 6 * DATA_W;
    localparam int M_TDATA_W = 2 * DATA_W;
    localparam int M_TUSER_W = 2;

    // Shared multiplier: a is the wide operand, b is scanned one bit per cycle
    localparam int MUL_A_W   = 68;
    localparam int MUL_B_W   = 34;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Shared restoring divider
    localparam int DIV_N_W   = DATA_W + FRAC_W;
    localparam int DIV_D_W   = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    // Triple product and volume
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int VOL_M_W = MUL_P_W - DATA_W;
    localparam logic [VOL_M_W-1:0] VOL_SAT_LIMIT = VOL_M_W'(6) << DATA_W;
    // Divide by six as (m/2)/3: times ceil(2^35/3) = 2^33 + 0xAAAAAAAB, then >> 35
    localparam int VOL_X_W      = 34;
    localparam logic [DATA_W-1:0] VOL_RECIP_LO = 32'hAAAA_AAAB;
    localparam int VOL_RECIP_HI = 33;
    localparam int VOL_Q_SH     = 35;

    // Strain and scale
    localparam int POLY_W = 40;
    localparam int SUM_W  = 48;
    localparam logic [DATA_W-1:0]  Q28_ONE      = DATA_W'(1) << FRAC_W;
    localparam logic [DATA_W-1:0]  INT32_MAX    = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  INT32_MIN    = 32'h8000_0000;
    localparam logic [DIV_N_W-1:0] STRAIN_Q_MAX = 60'd2415919103;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sd2147483647;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -48'sd2147483648;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [1:0] LAST_NB = 2'd3;

    // One closed atom, handed from front to back
    typedef struct packed {
        logic [NUM_NB-1:0][NUM_AXES-1:0][DIFF_W-1:0] v;
        logic [DATA_W-1:0] ref_volume;
        logic [DATA_W-1:0] lin_coef;
        logic [DATA_W-1:0] cubic_coef;
        logic              is_ligand;
        logic              diff_sat;
    } job_t;

    typedef struct packed {
        logic [DATA_W-1:0] volume;
        logic [DATA_W-1:0] scale;
        logic              zero_ref;
        logic              saturated;
    } result_t;

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
        logic [MUL_P_W-1:0] acc;
    } mul_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic [DIFF_W-1:0] v;
        logic              sat;
    } diff_clip_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_VOL,
        ST_REF,
        ST_DIV_STRAIN,
        ST_SCALE,
        ST_DONE
    } back_state_t;

    // Multiplier program of the back end
    typedef enum logic [3:0] {
        STEP_C0_POS,
        STEP_C0_NEG,
        STEP_T0,
        STEP_C1_POS,
        STEP_C1_NEG,
        STEP_T1,
        STEP_C2_POS,
        STEP_C2_NEG,
        STEP_T2,
        STEP_SQ,
        STEP_CUBE,
        STEP_LIN,
        STEP_CUB,
        STEP_VOL
    } step_t;

    // Neighbor difference a - b, clipped to COORD_WIDTH+1 signed bits
    function automatic diff_clip_t clip_diff(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        longint dl;
        longint lim;
        diff_clip_t r;
        d     = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
        dl    = longint'(d);
        lim   = longint'(1) <<< COORD_WIDTH;
        r.sat = 1'b0;
        if (dl > lim - 1)
        begin
            dl    = lim - 1;
            r.sat = 1'b1;
        end
        if (dl < -lim)
        begin
            dl    = -lim;
            r.sat = 1'b1;
        end
        r.v = dl[DIFF_W-1:0];
        return r;
    endfunction

endpackage

/* rtl/tss_mul.sv */
// ----------------------------------------------------------------------------
// tss_mul
// Shared signed multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tss_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  tss_pkg::mul_req_t  req,
    output tss_pkg::mul_rsp_t  rsp
);

    localparam int PW = tss_pkg::MUL_P_W;
    localparam int BW = tss_pkg::MUL_B_W;
    localparam int CW = tss_pkg::MUL_CNT_W;

    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] a_sh_reg, a_sh_next;
    logic [BW-1:0] b_sh_reg, b_sh_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW-1:0] a_ext;
    logic          last;

    // Step: add the shifted multiplicand; the sign bit of b weighs negative
    always_comb
    begin
        a_ext     = PW'($signed(req.a));
        last      = (cnt_reg == CW'(BW - 1));
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = req.acc;
            a_sh_next = req.neg ? (~a_ext + PW'(1)) : a_ext;
            b_sh_next = req.b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_sh_reg[0])
                acc_next = last ? (acc_reg - a_sh_reg) : (acc_reg + a_sh_reg);
            a_sh_next = a_sh_reg << 1;
            b_sh_next = b_sh_reg >> 1;
            cnt_next  = cnt_reg + CW'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

/* rtl/tss_div.sv */
// ----------------------------------------------------------------------------
// tss_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tss_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tss_pkg::div_req_t  req,
    output tss_pkg::div_rsp_t  rsp
);

    localparam int NW = tss_pkg::DIV_N_W;
    localparam int DW = tss_pkg::DIV_D_W;
    localparam int CW = tss_pkg::DIV_CNT_W;

    logic [NW-1:0] n_reg, n_next;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // Shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        trial     = {r_reg, n_reg[NW-1]};
        diff      = trial - {1'b0, d_reg};
        ge        = (trial >= {1'b0, d_reg});
        n_next    = n_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            n_next    = req.num;
            r_next    = '0;
            d_next    = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? diff[DW-1:0] : trial[DW-1:0];
            n_next   = {n_reg[NW-2:0], ge};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = n_reg;

endmodule

/* rtl/tss_front.sv */
// ----------------------------------------------------------------------------
// tss_front
// Takes neighbor transfers, holds the first three, closes an atom on the
// fourth and hands its difference vectors and coefficients to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tss_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tss_pkg::DATA_W-1:0]   pos_x,
    input  logic [tss_pkg::DATA_W-1:0]   pos_y,
    input  logic [tss_pkg::DATA_W-1:0]   pos_z,
    input  logic [tss_pkg::DATA_W-1:0]   ref_volume,
    input  logic [tss_pkg::DATA_W-1:0]   lin_coef,
    input  logic [tss_pkg::DATA_W-1:0]   cubic_coef,
    input  logic                         is_ligand,
    input  logic                         q_full,
    output logic                         push,
    output tss_pkg::job_t                job
);

    localparam int NB = tss_pkg::NUM_NB;
    localparam int AX = tss_pkg::NUM_AXES;

    logic [1:0]                   count_reg, count_next;
    logic [tss_pkg::DATA_W-1:0]   nb_reg [NB][AX];
    logic [tss_pkg::DATA_W-1:0]   pos [AX];
    logic                         accept;
    logic                         last;
    tss_pkg::diff_clip_t          dc;

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;

    // Fourth neighbor waits for room in the queue
    assign last     = (count_reg == tss_pkg::LAST_NB);
    assign in_ready = !last || !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && last;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
            count_next = last ? 2'd0 : count_reg + 2'd1;
    end

    // Difference vectors against the fourth neighbor
    always_comb
    begin
        job.diff_sat = 1'b0;
        dc           = '0;
        job.v        = '0;
        for (int k = 0; k < NB; k++)
        begin
            for (int c = 0; c < AX; c++)
            begin
                dc            = tss_pkg::clip_diff(nb_reg[k][c], pos[c]);
                job.v[k][c]   = dc.v;
                job.diff_sat  = job.diff_sat | dc.sat;
            end
        end
        job.ref_volume = ref_volume;
        job.lin_coef   = lin_coef;
        job.cubic_coef = cubic_coef;
        job.is_ligand  = is_ligand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Neighbor store
    always_ff @(posedge clk)
    begin
        if (accept && !last)
        begin
            for (int c = 0; c < AX; c++)
                nb_reg[count_reg][c] <= pos[c];
        end
    end

endmodule

/* rtl/tss_queue.sv */
// ----------------------------------------------------------------------------
// tss_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tss_queue #(
    parameter int DEPTH = tss_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tss_pkg::job_t  wdata,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output tss_pkg::job_t  rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tss_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    `ASSERT_NEVER(a_queue_overflow, push && full, "job pushed into full queue")
    `ASSERT_NEVER(a_queue_underflow, pop && empty, "job popped from empty queue")
    `ASSERT_NEVER(a_queue_count_range, cnt_reg > CNT_W'(DEPTH), "queue fill out of range")

endmodule

/* rtl/tss_back.sv */
// ----------------------------------------------------------------------------
// tss_back
// Back end: triple product, volume, strain and scale polynomial on one
// shared multiplier and one shared divider, then the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tss_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  tss_pkg::job_t     q_data,
    output logic              q_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output tss_pkg::result_t  res
);

    localparam int DW  = tss_pkg::DATA_W;
    localparam int VW  = tss_pkg::DIFF_W;
    localparam int AW  = tss_pkg::MUL_A_W;
    localparam int BW  = tss_pkg::MUL_B_W;
    localparam int PW  = tss_pkg::MUL_P_W;
    localparam int CRW = tss_pkg::CROSS_W;
    localparam int MW  = tss_pkg::VOL_M_W;
    localparam int FW  = tss_pkg::FRAC_W;
    localparam int YW  = tss_pkg::POLY_W;
    localparam int SW  = tss_pkg::SUM_W;
    localparam int XW  = tss_pkg::VOL_X_W;
    localparam int QS  = tss_pkg::VOL_Q_SH;

    tss_pkg::back_state_t state_reg, state_next;
    tss_pkg::step_t       step_reg, step_next;
    tss_pkg::job_t        job_reg, job_next;
    tss_pkg::result_t     res_reg, res_next;
    logic                 res_valid_reg, res_valid_next;

    logic signed [CRW-1:0] c_reg, c_next;
    logic signed [PW-1:0]  t_reg, t_next;
    logic [DW-1:0]         vol_reg, vol_next;
    logic signed [DW-1:0]  strain_reg, strain_next;
    logic signed [YW-1:0]  s2_reg, s2_next;
    logic signed [YW-1:0]  s3_reg, s3_next;
    logic signed [SW-1:0]  sum_reg, sum_next;
    logic [DW-1:0]         scale_reg, scale_next;
    logic                  sat_reg, sat_next;
    logic                  zref_reg, zref_next;

    tss_pkg::mul_req_t mul_req;
    tss_pkg::mul_rsp_t mul_rsp;
    tss_pkg::div_req_t div_req;
    tss_pkg::div_rsp_t div_rsp;

    logic signed [VW-1:0] vv [3][3];
    logic signed [AW-1:0] op_a;
    logic signed [BW-1:0] op_b;
    logic signed [PW-1:0] op_acc;
    logic                 op_neg;
    logic [PW-1:0]        t_abs;
    logic [MW-1:0]        m_val;

    tss_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    tss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Multiplier operands for each program step
    always_comb
    begin
        t_abs = t_reg[PW-1] ? (~t_reg + PW'(1)) : t_reg;
        m_val = t_abs[PW-1:DW];
        for (int k = 0; k < 3; k++)
            for (int c = 0; c < 3; c++)
                vv[k][c] = $signed(job_reg.v[k][c]);
        op_a   = '0;
        op_b   = '0;
        op_acc = '0;
        op_neg = 1'b0;
        case (step_reg)
            tss_pkg::STEP_C0_POS:
            begin
                op_a = AW'(vv[1][1]);
                op_b = BW'(vv[2][2]);
            end
            tss_pkg::STEP_C0_NEG:
            begin
                op_a   = AW'(vv[1][2]);
                op_b   = BW'(vv[2][1]);
                op_acc = PW'(c_reg);
                op_neg = 1'b1;
            end
            tss_pkg::STEP_T0:
            begin
                op_a = AW'(c_reg);
                op_b = BW'(vv[0][0]);
            end
            tss_pkg::STEP_C1_POS:
            begin
                op_a = AW'(vv[1][2]);
                op_b = BW'(vv[2][0]);
            end
            tss_pkg::STEP_C1_NEG:
            begin
                op_a   = AW'(vv[1][0]);
                op_b   = BW'(vv[2][2]);
                op_acc = PW'(c_reg);
                op_neg = 1'b1;
            end
            tss_pkg::STEP_T1:
            begin
                op_a   = AW'(c_reg);
                op_b   = BW'(vv[0][1]);
                op_acc = t_reg;
            end
            tss_pkg::STEP_C2_POS:
            begin
                op_a = AW'(vv[1][0]);
                op_b = BW'(vv[2][1]);
            end
            tss_pkg::STEP_C2_NEG:
            begin
                op_a   = AW'(vv[1][1]);
                op_b   = BW'(vv[2][0]);
                op_acc = PW'(c_reg);
                op_neg = 1'b1;
            end
            tss_pkg::STEP_T2:
            begin
                op_a   = AW'(c_reg);
                op_b   = BW'(vv[0][2]);
                op_acc = t_reg;
            end
            tss_pkg::STEP_SQ:
            begin
                op_a = AW'(strain_reg);
                op_b = BW'(strain_reg);
            end
            tss_pkg::STEP_CUBE:
            begin
                op_a = AW'(s2_reg);
                op_b = BW'(strain_reg);
            end
            tss_pkg::STEP_LIN:
            begin
                op_a = AW'($signed(job_reg.lin_coef));
                op_b = BW'(strain_reg);
            end
            tss_pkg::STEP_CUB:
            begin
                op_a = AW'(s3_reg);
                op_b = BW'($signed(job_reg.cubic_coef));
            end
            tss_pkg::STEP_VOL:
            begin
                // (m/2) times the reciprocal of three; its 2^33 part starts the sum
                op_a   = AW'(m_val[XW:1]);
                op_b   = BW'(tss_pkg::VOL_RECIP_LO);
                op_acc = PW'(m_val[XW:1]) << tss_pkg::VOL_RECIP_HI;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        job_next       = job_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        c_next         = c_reg;
        t_next         = t_reg;
        vol_next       = vol_reg;
        strain_next    = strain_reg;
        s2_next        = s2_reg;
        s3_next        = s3_reg;
        sum_next       = sum_reg;
        scale_next     = scale_reg;
        sat_next       = sat_reg;
        zref_next      = zref_reg;
        q_pop          = 1'b0;
        mul_req.start  = 1'b0;
        mul_req.neg    = op_neg;
        mul_req.a      = op_a;
        mul_req.b      = op_b;
        mul_req.acc    = op_acc;
        div_req.start  = 1'b0;
        div_req.num    = '0;
        div_req.den    = '0;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    job_next  = q_data;
                    step_next = tss_pkg::STEP_C0_POS;
                    zref_next = 1'b0;
                    if (q_data.is_ligand)
                    begin
                        vol_next   = '0;
                        scale_next = tss_pkg::Q28_ONE;
                        sat_next   = 1'b0;
                        state_next = tss_pkg::ST_DONE;
                    end
                    else
                    begin
                        sat_next   = q_data.diff_sat;
                        state_next = tss_pkg::ST_MUL_ISSUE;
                    end
                end
            end
            tss_pkg::ST_MUL_ISSUE:
            begin
                mul_req.start = 1'b1;
                state_next    = tss_pkg::ST_MUL_WAIT;
            end
            tss_pkg::ST_MUL_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    case (step_reg)
                        tss_pkg::STEP_T0, tss_pkg::STEP_T1, tss_pkg::STEP_T2:
                            t_next = $signed(mul_rsp.prod);
                        tss_pkg::STEP_SQ:
                            s2_next = $signed(mul_rsp.prod[YW+FW-1:FW]);
                        tss_pkg::STEP_CUBE:
                            s3_next = $signed(mul_rsp.prod[YW+FW-1:FW]);
                        tss_pkg::STEP_LIN:
                            sum_next = SW'($signed(tss_pkg::Q28_ONE))
                                     + SW'($signed(mul_rsp.prod[YW+FW-1:FW]));
                        tss_pkg::STEP_CUB:
                            sum_next = sum_reg + $signed(mul_rsp.prod[SW+FW-1:FW]);
                        tss_pkg::STEP_VOL:
                            vol_next = mul_rsp.prod[QS+DW-1:QS];
                        default:
                            c_next = $signed(mul_rsp.prod[CRW-1:0]);
                    endcase
                    if (step_reg == tss_pkg::STEP_T2)
                        state_next = tss_pkg::ST_VOL;
                    else if (step_reg == tss_pkg::STEP_CUB)
                        state_next = tss_pkg::ST_SCALE;
                    else if (step_reg == tss_pkg::STEP_VOL)
                        state_next = tss_pkg::ST_REF;
                    else
                    begin
                        step_next  = tss_pkg::step_t'(step_reg + 4'd1);
                        state_next = tss_pkg::ST_MUL_ISSUE;
                    end
                end
            end
            tss_pkg::ST_VOL:
            begin
                // |T| / 2^32 / 6, saturating at the top of the volume range
                if (m_val >= tss_pkg::VOL_SAT_LIMIT)
                begin
                    vol_next   = '1;
                    sat_next   = 1'b1;
                    state_next = tss_pkg::ST_REF;
                end
                else
                begin
                    step_next  = tss_pkg::STEP_VOL;
                    state_next = tss_pkg::ST_MUL_ISSUE;
                end
            end
            tss_pkg::ST_REF:
            begin
                if (job_reg.ref_volume == '0)
                begin
                    zref_next  = 1'b1;
                    scale_next = tss_pkg::Q28_ONE;
                    state_next = tss_pkg::ST_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {vol_reg, {FW{1'b0}}};
                    div_req.den   = job_reg.ref_volume;
                    state_next    = tss_pkg::ST_DIV_STRAIN;
                end
            end
            tss_pkg::ST_DIV_STRAIN:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quo > tss_pkg::STRAIN_Q_MAX)
                    begin
                        strain_next = $signed(tss_pkg::INT32_MAX);
                        sat_next    = 1'b1;
                    end
                    else
                        strain_next = $signed(div_rsp.quo[DW-1:0] - tss_pkg::Q28_ONE);
                    step_next  = tss_pkg::STEP_SQ;
                    state_next = tss_pkg::ST_MUL_ISSUE;
                end
            end
            tss_pkg::ST_SCALE:
            begin
                if (sum_reg > tss_pkg::SUM_MAX)
                begin
                    scale_next = tss_pkg::INT32_MAX;
                    sat_next   = 1'b1;
                end
                else if (sum_reg < tss_pkg::SUM_MIN)
                begin
                    scale_next = tss_pkg::INT32_MIN;
                    sat_next   = 1'b1;
                end
                else
                    scale_next = sum_reg[DW-1:0];
                state_next = tss_pkg::ST_DONE;
            end
            tss_pkg::ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.volume    = vol_reg;
                    res_next.scale     = scale_reg;
                    res_next.zero_ref  = zref_reg;
                    res_next.saturated = sat_reg;
                    res_valid_next     = 1'b1;
                    state_next         = tss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tss_pkg::ST_IDLE;
            end
        endcase
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tss_pkg::ST_IDLE;
            step_reg      <= tss_pkg::STEP_C0_POS;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        res_reg    <= res_next;
        c_reg      <= c_next;
        t_reg      <= t_next;
        vol_reg    <= vol_next;
        strain_reg <= strain_next;
        s2_reg     <= s2_next;
        s3_reg     <= s3_next;
        sum_reg    <= sum_next;
        scale_reg  <= scale_next;
        sat_reg    <= sat_next;
        zref_reg   <= zref_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `ASSERT_NEVER(a_mul_start_busy, mul_req.start && mul_rsp.busy, "multiply issued while busy")
    `ASSERT_NEVER(a_div_start_busy, div_req.start && div_rsp.busy, "divide issued while busy")
    `ASSERT_PROP(a_mul_runs, mul_req.start |=> mul_rsp.busy, "multiplier did not start")

endmodule

/* rtl/tetrahedron_strain_scale_top.sv */
// ----------------------------------------------------------------------------
// tetrahedron_strain_scale_top
// Neighbor tetrahedron volume and strain scale of one atom per four
// neighbor transfers.
//
// Channel   Dir  tdata                                        tuser
// s_axis    in   pos_x,pos_y,pos_z,ref_volume,lin,cubic (192)  is_ligand (1)
// m_axis    out  volume, scale (64)                           zero_ref,saturated
//
// Neighbor transfers are taken one per cycle; the fourth waits only when the
// job queue is full. A non-ligand atom runs the triple product, divide by six
// (skipped if the volume saturates) and strain polynomial on the bit-serial
// multiplier and the strain on the restoring divider; a zero reference skips
// strain and polynomial, a ligand atom skips all. Reset is asynchronous and
// clears the neighbor count, the queue and the result valid flag. A stalled
// m_axis holds one result while the front keeps filling the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tetrahedron_strain_scale_top #(
    parameter int QUEUE_DEPTH = tss_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x, pos_y, pos_z, ref_volume, lin_coef, cubic_coef
    input  logic [tss_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // is_ligand
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // volume, scale
    output logic [tss_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // zero_ref, saturated
    output logic [tss_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    localparam int DW = tss_pkg::DATA_W;

    tss_pkg::job_t    push_job;
    tss_pkg::job_t    head_job;
    tss_pkg::result_t res;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;

    tss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .pos_x      (s_axis_tdata[DW-1:0]),
        .pos_y      (s_axis_tdata[2*DW-1:DW]),
        .pos_z      (s_axis_tdata[3*DW-1:2*DW]),
        .ref_volume (s_axis_tdata[4*DW-1:3*DW]),
        .lin_coef   (s_axis_tdata[5*DW-1:4*DW]),
        .cubic_coef (s_axis_tdata[6*DW-1:5*DW]),
        .is_ligand  (s_axis_tuser),
        .q_full     (q_full),
        .push       (push),
        .job        (push_job)
    );

    tss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_job),
        .full  (q_full),
        .pop   (pop),
        .empty (q_empty),
        .rdata (head_job)
    );

    tss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (head_job),
        .q_pop     (pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {res.scale, res.volume};
    assign m_axis_tuser = {res.saturated, res.zero_ref};

endmodule

/* tb/tetrahedron_strain_scale_top_tb.sv */
// ----------------------------------------------------------------------------
// tetrahedron_strain_scale_top_tb
// Drives four-transfer atoms into the strain scale block and checks every
// result against an in-bench predictor or its row's expected values. A short
// directed table (ligand, zero reference, extremes, unit tetrahedron) comes
// first, then random atoms with random gaps and backpressure on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tetrahedron_strain_scale_top_tb;

    localparam int RAND_ATOMS = 330;
    localparam int GAP_PCT    = 7;
    localparam int DRAIN_CYC  = 800;

    typedef struct {
        logic [31:0] volume;
        logic [31:0] scale;
        logic        zero_ref;
        logic        saturated;
    } strain_res_t;

    typedef struct {
        logic [31:0] x, y, z, ref_vol, lin, cub;
        logic        lig;
        bit          typed;
        strain_res_t res;
    } nb_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [tss_pkg::S_TDATA_W-1:0]  s_axis_tdata;   // pos_x, pos_y, pos_z, ref_volume, lin, cubic
    logic                           s_axis_tuser;   // is_ligand
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [tss_pkg::M_TDATA_W-1:0]  m_axis_tdata;   // volume, scale
    logic [tss_pkg::M_TUSER_W-1:0]  m_axis_tuser;   // zero_ref, saturated

    logic [31:0]  held_nb [0:8];
    int           held_cnt;
    strain_res_t  pending_res [$];
    int           err_cnt;
    int           res_cnt;
    int           atom_cnt;
    bit           steady_in;
    bit           steady_out;
    nb_row_t      dir_tab [$];

    tetrahedron_strain_scale_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // Sign-extend a 32-bit word to the wide working width
    function automatic logic signed [127:0] sx(input logic [31:0] v);
        logic signed [127:0] r;
        r = $signed(v);
        return r;
    endfunction

    // Volume and strain scale of the atom closed by the fourth neighbor
    function automatic strain_res_t close_atom(input logic [31:0] px, py, pz,
                                               input logic [31:0] rv, lc, cc,
                                               input logic lig);
        logic signed [127:0] d [0:2][0:2];
        logic signed [127:0] p4 [0:2];
        logic signed [127:0] c0, c1, c2, t, strain, s2, s3, lterm, cterm, sc;
        logic [127:0]        mag, q;
        strain_res_t         r;
        r.volume = '0; r.scale = tss_pkg::Q28_ONE; r.zero_ref = 1'b0; r.saturated = 1'b0;
        if (lig)
            return r;
        p4[0] = sx(px); p4[1] = sx(py); p4[2] = sx(pz);
        for (int k = 0; k < 3; k++)
            for (int c = 0; c < 3; c++)
                d[k][c] = sx(held_nb[3*k+c]) - p4[c];
        c0 = d[1][1] * d[2][2] - d[1][2] * d[2][1];
        c1 = d[1][2] * d[2][0] - d[1][0] * d[2][2];
        c2 = d[1][0] * d[2][1] - d[1][1] * d[2][0];
        t  = c0 * d[0][0] + c1 * d[0][1] + c2 * d[0][2];
        if (t < 0)
            t = -t;
        mag = t;
        q   = (mag >> 32) / 6;
        if (q > 128'hFFFF_FFFF)
        begin
            r.volume    = 32'hFFFF_FFFF;
            r.saturated = 1'b1;
        end
        else
            r.volume = q[31:0];
        if (rv == 0)
        begin
            r.zero_ref = 1'b1;
            return r;
        end
        q      = ({96'd0, r.volume} << 28) / {96'd0, rv};
        strain = $signed(q) - sx(tss_pkg::Q28_ONE);
        if (strain > sx(tss_pkg::INT32_MAX))
        begin
            strain      = sx(tss_pkg::INT32_MAX);
            r.saturated = 1'b1;
        end
        s2    = (strain * strain) >>> 28;
        s3    = (s2 * strain) >>> 28;
        lterm = (sx(lc) * strain) >>> 28;
        cterm = (sx(cc) * s3) >>> 28;
        sc    = sx(tss_pkg::Q28_ONE) + lterm + cterm;
        if (sc > sx(tss_pkg::INT32_MAX))
        begin
            sc          = sx(tss_pkg::INT32_MAX);
            r.saturated = 1'b1;
        end
        if (sc < sx(tss_pkg::INT32_MIN))
        begin
            sc          = sx(tss_pkg::INT32_MIN);
            r.saturated = 1'b1;
        end
        r.scale = sc[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_v);
        $display("MISMATCH result %0d %s: got %h expected %h", res_cnt, what, got, exp_v);
        err_cnt++;
    endtask

    // Send one neighbor transfer; on acceptance update the predictor
    task automatic send_nb(input nb_row_t row);
        strain_res_t r;
        while (!steady_in && $urandom_range(99) < GAP_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row.cub, row.lin, row.ref_vol, row.z, row.y, row.x};
        s_axis_tuser  <= row.lig;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (held_cnt < 3)
        begin
            held_nb[3*held_cnt]   = row.x;
            held_nb[3*held_cnt+1] = row.y;
            held_nb[3*held_cnt+2] = row.z;
            held_cnt++;
        end
        else
        begin
            r = close_atom(row.x, row.y, row.z, row.ref_vol, row.lin, row.cub, row.lig);
            pending_res.push_back(row.typed ? row.res : r);
            held_cnt = 0;
            atom_cnt++;
        end
    endtask

    function automatic nb_row_t mk(input logic [31:0] x, y, z, rv, lc, cc,
                                   input logic lig);
        nb_row_t row;
        row.x = x; row.y = y; row.z = z; row.ref_vol = rv; row.lin = lc; row.cub = cc;
        row.lig = lig; row.typed = 0;
        row.res = '{32'd0, 32'd0, 1'b0, 1'b0};
        return row;
    endfunction

    function automatic nb_row_t mk_exp(input nb_row_t row, input logic [31:0] vol,
                                       input logic [31:0] sc, input logic zr, sat);
        row.typed = 1;
        row.res   = '{vol, sc, zr, sat};
        return row;
    endfunction

    // Output side: random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady_out || ($urandom_range(99) >= GAP_PCT);
    end

    // Result checker
    always @(posedge clk)
    begin
        strain_res_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_res.size() == 0)
                report_mismatch("unexpected volume", m_axis_tdata[31:0], 32'd0);
            else
            begin
                e = pending_res.pop_front();
                if (m_axis_tdata[31:0] !== e.volume)
                    report_mismatch("volume", m_axis_tdata[31:0], e.volume);
                if (m_axis_tdata[63:32] !== e.scale)
                    report_mismatch("scale", m_axis_tdata[63:32], e.scale);
                if (m_axis_tuser[0] !== e.zero_ref)
                    report_mismatch("zero_ref", m_axis_tuser[0], e.zero_ref);
                if (m_axis_tuser[1] !== e.saturated)
                    report_mismatch("saturated", m_axis_tuser[1], e.saturated);
            end
            res_cnt++;
        end
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("tetrahedron_strain_scale_top_tb failed");
        $finish;
    end

    initial
    begin
        logic [31:0] cx, cy, cz, q1;
        logic        lig;
        nb_row_t     row;
        int          wait_cyc;
        clk = 0; rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = 0;
        err_cnt = 0; res_cnt = 0; atom_cnt = 0; held_cnt = 0;
        steady_in = 0; steady_out = 0;
        q1 = 32'h0001_0000;
        for (int i = 0; i < 9; i++)
            held_nb[i] = '0;

        // Ligand atom with extreme coordinates: volume 0, scale one
        dir_tab.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1, '1, 1));
        dir_tab.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1, '1, 0));
        dir_tab.push_back(mk('1, 0, '1, 0, 0, 0, 1));
        dir_tab.push_back(mk_exp(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          '1, 32'h7FFF_FFFF, 32'h8000_0000, 1), 0, tss_pkg::Q28_ONE, 0, 0));
        // Degenerate atom with zero reference
        for (int i = 0; i < 3; i++)
            dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_exp(mk(0, 0, 0, 0, 0, 0, 0), 0, tss_pkg::Q28_ONE, 1, 0));
        // Unit tetrahedron at its own reference: strain zero
        dir_tab.push_back(mk(q1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(0, q1, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(0, 0, q1, 0, 0, 0, 0));
        dir_tab.push_back(mk_exp(mk(0, 0, 0, 32'd10922, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0),
                          32'd10922, tss_pkg::Q28_ONE, 0, 0));
        // Extreme coordinates: volume clips, tiny reference clips the strain
        dir_tab.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
        dir_tab.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));
        dir_tab.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
        dir_tab.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        // Small volume against the largest reference, negative coefficients
        dir_tab.push_back(mk(q1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(0, q1, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(0, 0, q1, 0, 0, 0, 0));
        dir_tab.push_back(mk(0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0));
        // Mid-size coordinates, volume clips, negative extreme coefficients, scale clips low
        dir_tab.push_back(mk(32'h0100_0000, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(0, 32'h0100_0000, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(0, 0, 32'h0100_0000, 0, 0, 0, 0));
        dir_tab.push_back(mk(0, 0, 0, 32'd3, 32'h8000_0000, 32'h8000_0000, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_nb(dir_tab[i]);

        // Random atoms: mostly compact clusters, some full-range, some ligands
        for (int a = 0; a < RAND_ATOMS; a++)
        begin
            steady_in  = (a >= 120 && a < 170);
            steady_out = (a >= 140 && a < 200);
            cx = $urandom; cy = $urandom; cz = $urandom;
            lig = ($urandom_range(99) < 15);
            for (int n = 0; n < 4; n++)
            begin
                if ($urandom_range(99) < 25)
                    row = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(1));
                else
                    row = mk(cx + $urandom_range(32'h4_0000) - 32'h2_0000,
                             cy + $urandom_range(32'h4_0000) - 32'h2_0000,
                             cz + $urandom_range(32'h4_0000) - 32'h2_0000,
                             $urandom_range(99) < 5 ? 32'd0 :
                             ($urandom_range(1) ? $urandom_range(32'h10_0000) : $urandom),
                             $urandom, $urandom, $urandom_range(1));
                if (n == 3)
                    row.lig = lig;
                send_nb(row);
            end
        end
        s_axis_tvalid <= 1'b0;
        steady_out = 0;

        wait_cyc = 0;
        while (pending_res.size() != 0 && wait_cyc < 200000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Checked %0d results from %0d atoms (%0d directed rows, %0d random atoms).",
                 res_cnt, atom_cnt, dir_tab.size(), RAND_ATOMS);
        if (pending_res.size() != 0)
            report_mismatch("results never arrived", 32'(pending_res.size()), 32'd0);
        if (err_cnt == 0)
            $display("tetrahedron_strain_scale_top_tb passed");
        else
            $display("tetrahedron_strain_scale_top_tb failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/tss_pkg.sv
rtl/tss_mul.sv
rtl/tss_div.sv
rtl/tss_front.sv
rtl/tss_queue.sv
rtl/tss_back.sv
rtl/tetrahedron_strain_scale_top.sv
tb/tetrahedron_strain_scale_top_tb.sv
